[hw/rtl/sha1_bsh_pkg.sv]
// Shared types and constants for the SHA-1 byte stream hasher.
`timescale 1ns / 1ps
`default_nettype none

package sha1_bsh_pkg;

  // Input command codes
  localparam logic [1:0] CMD_ABSORB        = 2'd0;
  localparam logic [1:0] CMD_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] CMD_FINISH        = 2'd2;

  // Initial chaining value
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  // Round constants
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] LEN_LAST   = 3'd7;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  typedef enum logic [1:0] {
    BSEL_DATA,
    BSEL_PAD,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic      push;
    byte_sel_e byte_sel;
    logic [2:0] len_idx;
    logic      len_add;
    logic      len_clear;
    logic      work_load;
    logic      round_en;
    logic [6:0] round_idx;
    logic      chain_add;
    logic      chain_reset;
    logic      digest_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/sha1_bsh_dp.sv]
// Datapath: block window, round logic, chaining value, length and digest output.
`timescale 1ns / 1ps
`default_nettype none

module sha1_bsh_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [7:0]           data_byte_i,
  input  wire sha1_bsh_pkg::dp_cmd_t cmd_i,
  output sha1_bsh_pkg::dp_stat_t    stat_o,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [31:0]               digest_word_o,
  output logic [2:0]                word_index_o,
  output logic                      last_word_o
);

  logic [511:0]     win_q, win_d;
  logic [31:0]      a_q, b_q, c_q, d_q, e_q;
  logic [31:0]      a_d, b_d, c_d, d_d, e_d;
  logic [4:0][31:0] chain_q, chain_d;
  logic [5:0]       fill_q, fill_d;
  logic [63:0]      len_q, len_d;
  logic [159:0]     dig_q, dig_d;
  logic [2:0]       oidx_q, oidx_d;
  logic             ovld_q, ovld_d;

  logic [7:0]  push_byte;
  logic [63:0] len_shift;
  logic [31:0] w_cur, w_mix, w_new, f_val, k_val, t_val;

  always_comb begin
    len_shift = len_q << {cmd_i.len_idx, 3'b000};
    case (cmd_i.byte_sel)
      sha1_bsh_pkg::BSEL_DATA: push_byte = data_byte_i;
      sha1_bsh_pkg::BSEL_PAD:  push_byte = sha1_bsh_pkg::PAD_BYTE;
      sha1_bsh_pkg::BSEL_LEN:  push_byte = len_shift[63:56];
      default:                 push_byte = 8'h00;
    endcase
  end

  // Window holds W[t..t+15], W[t] in the top word
  assign w_cur = win_q[511:480];
  assign w_mix = win_q[95:64] ^ win_q[255:224] ^ win_q[447:416] ^ win_q[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (cmd_i.round_idx inside {[7'd0:7'd19]}) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = sha1_bsh_pkg::K0;
    end else if (cmd_i.round_idx inside {[7'd20:7'd39]}) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1_bsh_pkg::K1;
    end else if (cmd_i.round_idx inside {[7'd40:7'd59]}) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = sha1_bsh_pkg::K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1_bsh_pkg::K3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;

  always_comb begin
    win_d   = win_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    e_d     = e_q;
    chain_d = chain_q;
    fill_d  = fill_q;
    len_d   = len_q;
    dig_d   = dig_q;
    oidx_d  = oidx_q;
    ovld_d  = ovld_q;

    if (cmd_i.push) begin
      win_d  = {win_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
    end else if (cmd_i.round_en) begin
      win_d = {win_q[479:0], w_new};
    end

    if (cmd_i.len_add) begin
      len_d = len_q + 64'd8;
    end else if (cmd_i.len_clear) begin
      len_d = '0;
    end

    if (cmd_i.work_load) begin
      a_d = chain_q[0];
      b_d = chain_q[1];
      c_d = chain_q[2];
      d_d = chain_q[3];
      e_d = chain_q[4];
    end else if (cmd_i.round_en) begin
      a_d = t_val;
      b_d = a_q;
      c_d = {b_q[1:0], b_q[31:2]};
      d_d = c_q;
      e_d = d_q;
    end

    if (cmd_i.chain_add) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
    end else if (cmd_i.chain_reset) begin
      chain_d = {sha1_bsh_pkg::IV4, sha1_bsh_pkg::IV3, sha1_bsh_pkg::IV2,
                 sha1_bsh_pkg::IV1, sha1_bsh_pkg::IV0};
    end

    // Digest output register drains one word per transaction
    if (cmd_i.digest_load) begin
      dig_d  = {chain_q[0], chain_q[1], chain_q[2], chain_q[3], chain_q[4]};
      oidx_d = '0;
      ovld_d = 1'b1;
    end else if (ovld_q && out_ready_i) begin
      if (oidx_q == sha1_bsh_pkg::WORD_LAST) begin
        ovld_d = 1'b0;
      end else begin
        oidx_d = oidx_q + 3'd1;
        dig_d  = {dig_q[127:0], 32'h0000_0000};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= {sha1_bsh_pkg::IV4, sha1_bsh_pkg::IV3, sha1_bsh_pkg::IV2,
                  sha1_bsh_pkg::IV1, sha1_bsh_pkg::IV0};
      fill_q  <= '0;
      len_q   <= '0;
      oidx_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      chain_q <= chain_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      oidx_q  <= oidx_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
    dig_q <= dig_d;
  end

  assign stat_o.fill     = fill_q;
  assign stat_o.out_busy = ovld_q;

  assign out_valid_o   = ovld_q;
  assign digest_word_o = dig_q[159:128];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == sha1_bsh_pkg::WORD_LAST);

endmodule

`default_nettype wire

[hw/rtl/sha1_bsh_ctrl.sv]
// Controller: command decode, padding sequence, round count and digest handoff.
`timescale 1ns / 1ps
`default_nettype none

module sha1_bsh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        cmd_i,
  input  wire sha1_bsh_pkg::dp_stat_t stat_i,
  output sha1_bsh_pkg::dp_cmd_t  dp_cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD80  = 3'd1;
  localparam logic [2:0] ST_PADZ   = 3'd2;
  localparam logic [2:0] ST_PADLEN = 3'd3;
  localparam logic [2:0] ST_CINIT  = 3'd4;
  localparam logic [2:0] ST_ROUND  = 3'd5;
  localparam logic [2:0] ST_CADD   = 3'd6;
  localparam logic [2:0] ST_DIGEST = 3'd7;

  // Where to resume after a block compression
  localparam logic [1:0] PH_NONE   = 2'd0;
  localparam logic [1:0] PH_NEED80 = 2'd1;
  localparam logic [1:0] PH_ZERO   = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  logic [2:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] lcnt_q, lcnt_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    rnd_d      = rnd_q;
    lcnt_d     = lcnt_q;
    in_ready_o = 1'b0;
    dp_cmd_o   = '0;
    dp_cmd_o.byte_sel  = sha1_bsh_pkg::BSEL_DATA;
    dp_cmd_o.len_idx   = lcnt_q;
    dp_cmd_o.round_idx = rnd_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (cmd_i)
            sha1_bsh_pkg::CMD_ABSORB, sha1_bsh_pkg::CMD_ABSORB_FINISH: begin
              dp_cmd_o.push    = 1'b1;
              dp_cmd_o.len_add = 1'b1;
              if (stat_i.fill == sha1_bsh_pkg::FILL_LAST) begin
                phase_d = (cmd_i == sha1_bsh_pkg::CMD_ABSORB_FINISH) ? PH_NEED80 : PH_NONE;
                state_d = ST_CINIT;
              end else if (cmd_i == sha1_bsh_pkg::CMD_ABSORB_FINISH) begin
                state_d = ST_PAD80;
              end
            end
            sha1_bsh_pkg::CMD_FINISH: begin
              state_d = ST_PAD80;
            end
            default: ; // unused code: dropped
          endcase
        end
      end
      ST_PAD80: begin
        dp_cmd_o.push     = 1'b1;
        dp_cmd_o.byte_sel = sha1_bsh_pkg::BSEL_PAD;
        phase_d           = PH_ZERO;
        state_d = (stat_i.fill == sha1_bsh_pkg::FILL_LAST) ? ST_CINIT : ST_PADZ;
      end
      ST_PADZ: begin
        if (stat_i.fill == sha1_bsh_pkg::FILL_LEN) begin
          lcnt_d  = '0;
          state_d = ST_PADLEN;
        end else begin
          dp_cmd_o.push     = 1'b1;
          dp_cmd_o.byte_sel = sha1_bsh_pkg::BSEL_ZERO;
          if (stat_i.fill == sha1_bsh_pkg::FILL_LAST) begin
            state_d = ST_CINIT;
          end
        end
      end
      ST_PADLEN: begin
        dp_cmd_o.push     = 1'b1;
        dp_cmd_o.byte_sel = sha1_bsh_pkg::BSEL_LEN;
        if (lcnt_q == sha1_bsh_pkg::LEN_LAST) begin
          phase_d = PH_DONE;
          state_d = ST_CINIT;
        end else begin
          lcnt_d = lcnt_q + 3'd1;
        end
      end
      ST_CINIT: begin
        dp_cmd_o.work_load = 1'b1;
        rnd_d              = '0;
        state_d            = ST_ROUND;
      end
      ST_ROUND: begin
        dp_cmd_o.round_en = 1'b1;
        if (rnd_q == sha1_bsh_pkg::ROUND_LAST) begin
          state_d = ST_CADD;
        end else begin
          rnd_d = rnd_q + 7'd1;
        end
      end
      ST_CADD: begin
        dp_cmd_o.chain_add = 1'b1;
        case (phase_q)
          PH_NEED80: state_d = ST_PAD80;
          PH_ZERO:   state_d = ST_PADZ;
          PH_DONE:   state_d = ST_DIGEST;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_DIGEST: begin
        // hold until the previous digest has fully drained
        if (!stat_i.out_busy) begin
          dp_cmd_o.digest_load = 1'b1;
          dp_cmd_o.chain_reset = 1'b1;
          dp_cmd_o.len_clear   = 1'b1;
          phase_d              = PH_NONE;
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_NONE;
      rnd_q   <= '0;
      lcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      rnd_q   <= rnd_d;
      lcnt_q  <= lcnt_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sha1_byte_stream_hasher.sv]
// Top level of the SHA-1 byte stream hasher.
// Input channel (in_valid_i/in_ready_o) carries cmd_i and data_byte_i: absorb a
// byte, absorb a byte and finish, or finish without a byte; code 3 is taken and
// dropped. Output channel (out_valid_o/out_ready_i) carries the five digest
// words, word_index_o 0 first, last_word_o on the fifth.
// The 64th byte of a block starts the compression (load, 80 rounds at one round
// per cycle, chain add); no input is taken until it ends.
// A finish pushes the padding bytes at one per cycle (0x80, zeros to offset 56,
// 8 length bytes), paused while a block compresses, then compresses once or
// twice; the first digest word is held back while the previous digest is
// still draining.
// The digest sits in its own output register, so new input is taken while the
// words drain; a later finish waits for the previous digest to be taken.
// A stalled receiver holds the current word steady until it is taken.
// Reset (rst_ni low, asynchronous) restores the initial chaining value, clears
// the fill count and the bit length, and drops any pending output words.
`timescale 1ns / 1ps
`default_nettype none

module sha1_byte_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  sha1_bsh_pkg::dp_cmd_t  dp_cmd;
  sha1_bsh_pkg::dp_stat_t dp_stat;

  sha1_bsh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (dp_stat),
    .dp_cmd_o   (dp_cmd)
  );

  sha1_bsh_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (data_byte_i),
    .cmd_i         (dp_cmd),
    .stat_o        (dp_stat),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .digest_word_o (digest_word_o),
    .word_index_o  (word_index_o),
    .last_word_o   (last_word_o)
  );

endmodule

`default_nettype wire

[hw/rtl/sha1_bsh_checker.sv]
// Port-level checker for the SHA-1 byte stream hasher, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sha1_bsh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] digest_word_o,
  input wire logic [2:0]  word_index_o,
  input wire logic        last_word_o
);

  // A stalled output transaction keeps its word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digest_word_o)
      && $stable(word_index_o))
    else $error("output word changed while stalled");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> word_index_o <= 3'd4)
    else $error("word index out of range");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_word_o == (word_index_o == 3'd4)))
    else $error("last word flag does not match index");

  // Words of one digest go out back to back in order
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_word_o |=>
      out_valid_o && (word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest words not in sequence");

endmodule

bind sha1_byte_stream_hasher sha1_bsh_checker u_sha1_bsh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .digest_word_o (digest_word_o),
  .word_index_o  (word_index_o),
  .last_word_o   (last_word_o)
);

`default_nettype wire

[bench/sha1_byte_stream_hasher_tb.sv]
// Self-checking bench for the SHA-1 byte stream hasher: random messages, digest predictor.
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_tb;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 3000;
  localparam int TAIL_CYCLES = 400;

  typedef struct {
    logic [1:0] cmd;
    logic [7:0] data;
  } byte_txn_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  typedef enum int {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_e;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic        src_valid = 1'b0;
  logic [1:0]  src_cmd = sha1_bsh_pkg::CMD_ABSORB;
  logic [7:0]  src_data = 8'h00;
  logic        snk_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  sha1_byte_stream_hasher dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (src_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (src_cmd),
    .data_byte_i   (src_data),
    .out_valid_o   (out_valid),
    .out_ready_i   (snk_ready),
    .digest_word_o (digest_word),
    .word_index_o  (word_index),
    .last_word_o   (last_word)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_txn_t    pending_bytes[$];
  digest_word_t digest_expected[$];
  int errors = 0;
  int items_queued = 0;
  int finishes_queued = 0;

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  // ---------------- digest predictor ----------------
  logic [31:0] hv [5];
  logic [7:0]  blk [64] = '{default: 8'h00};
  int          fill;
  logic [63:0] nbits;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void sha1_restart();
    hv[0] = sha1_bsh_pkg::IV0;
    hv[1] = sha1_bsh_pkg::IV1;
    hv[2] = sha1_bsh_pkg::IV2;
    hv[3] = sha1_bsh_pkg::IV3;
    hv[4] = sha1_bsh_pkg::IV4;
    fill = 0;
    nbits = 64'd0;
  endfunction

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int r = 0; r < 16; r++)
      w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (int r = 16; r < 80; r++)
      w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
    a = hv[0];
    b = hv[1];
    c = hv[2];
    d = hv[3];
    e = hv[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = sha1_bsh_pkg::K0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = sha1_bsh_pkg::K1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1_bsh_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1_bsh_pkg::K3;
      end
      t = rotl(a, 5) + f + e + k + w[r];
      e = d;
      d = c;
      c = rotl(b, 30);
      b = a;
      a = t;
    end
    hv[0] += a;
    hv[1] += b;
    hv[2] += c;
    hv[3] += d;
    hv[4] += e;
  endfunction

  function automatic void sha1_push(input logic [7:0] v);
    blk[fill] = v;
    fill++;
    if (fill == 64) begin
      sha1_compress();
      fill = 0;
    end
  endfunction

  function automatic void sha1_predict(input logic [1:0] cmd, input logic [7:0] data);
    logic [63:0] len;
    digest_word_t dw;
    if (cmd == CMD_UNUSED) return;
    if (cmd == sha1_bsh_pkg::CMD_ABSORB || cmd == sha1_bsh_pkg::CMD_ABSORB_FINISH) begin
      nbits += 64'd8;
      sha1_push(data);
    end
    if (cmd == sha1_bsh_pkg::CMD_ABSORB) return;
    len = nbits;
    sha1_push(sha1_bsh_pkg::PAD_BYTE);
    while (fill != int'(sha1_bsh_pkg::FILL_LEN)) sha1_push(8'h00);
    for (int i = 0; i < 8; i++) blk[56+i] = len[63-8*i -: 8];
    sha1_compress();
    for (int i = 0; i < 5; i++) begin
      dw.word = hv[i];
      dw.idx  = 3'(i);
      dw.last = (i == int'(sha1_bsh_pkg::WORD_LAST));
      digest_expected.push_back(dw);
    end
    sha1_restart();
  endfunction

  initial sha1_restart();

  // ---------------- stimulus queue ----------------
  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] data);
    byte_txn_t it;
    it.cmd = cmd;
    it.data = data;
    pending_bytes.push_back(it);
    if (cmd != CMD_UNUSED) items_queued++;
    if (cmd == sha1_bsh_pkg::CMD_ABSORB_FINISH || cmd == sha1_bsh_pkg::CMD_FINISH)
      finishes_queued++;
  endtask

  // Message of nbytes bytes; the last byte may ride on the finish command.
  // Unused command codes are sprinkled in as noise.
  task automatic add_message(input int nbytes);
    bit last_with_byte;
    last_with_byte = (nbytes > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < nbytes; i++) begin
      if ($urandom_range(0, 19) == 0) queue_item(CMD_UNUSED, 8'($urandom));
      if (last_with_byte && i == nbytes - 1)
        queue_item(sha1_bsh_pkg::CMD_ABSORB_FINISH, 8'($urandom));
      else queue_item(sha1_bsh_pkg::CMD_ABSORB, 8'($urandom));
    end
    if (!last_with_byte) queue_item(sha1_bsh_pkg::CMD_FINISH, 8'($urandom));
  endtask

  // ---------------- driver ----------------
  int burst_left = 0;
  int gap_left = 0;
  int hold_cnt = 0;

  always @(posedge clk_i) begin : feed_proc
    bit offer;
    byte_txn_t it;
    int r;
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else begin
      offer = src_valid;
      if (src_valid && in_ready) begin
        sha1_predict(src_cmd, src_data);
        offer = 1'b0;
      end
      // keep offering while the receiver is held off so the input backs up
      if (hold_cnt > 0) gap_left = 0;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0) begin
          it = pending_bytes.pop_front();
          src_cmd <= it.cmd;
          src_data <= it.data;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 20);
            r = $urandom_range(0, 9);
            if (r < 4) gap_left = 0;
            else if (r < 8) gap_left = $urandom_range(1, 4);
            else if (r < 9) gap_left = $urandom_range(5, 40);
            else gap_left = $urandom_range(100, 250);
          end
        end
      end
      src_valid <= offer;
    end
  end

  // ---------------- receiver ready pattern ----------------
  int words_seen = 0;
  bit hold_done = 1'b0;
  sink_mode_e sink_mode = SINK_OPEN;
  int mode_left = 0;

  always @(posedge clk_i) begin : sink_proc
    bit rdy;
    if (!rst_n) begin
      snk_ready <= 1'b0;
    end else begin
      if (out_valid && snk_ready) words_seen++;
      if (hold_cnt > 0) begin
        hold_cnt--;
        rdy = 1'b0;
      end else if (!hold_done && words_seen >= 12) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          sink_mode = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(20, 300);
        end else begin
          mode_left--;
        end
        case (sink_mode)
          SINK_OPEN:   rdy = 1'b1;
          SINK_CHOPPY: rdy = 1'($urandom_range(0, 1));
          default:     rdy = ($urandom_range(0, 7) == 0);
        endcase
      end
      snk_ready <= rdy;
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin : check_proc
    digest_word_t dw;
    if (rst_n && out_valid && snk_ready) begin
      if (digest_expected.size() == 0) begin
        flag_error($sformatf("unexpected digest word %08h idx %0d", digest_word, word_index));
      end else begin
        dw = digest_expected.pop_front();
        if (digest_word !== dw.word)
          flag_error($sformatf("digest_word %08h, want %08h", digest_word, dw.word));
        if (word_index !== dw.idx)
          flag_error($sformatf("word_index %0d, want %0d", word_index, dw.idx));
        if (last_word !== dw.last)
          flag_error($sformatf("last_word %0b, want %0b", last_word, dw.last));
      end
    end
  end

  // ---------------- sequence and end of run ----------------
  initial begin : main_proc
    int r;
    int n;
    // directed part
    queue_item(sha1_bsh_pkg::CMD_FINISH, 8'hA5);         // empty message
    queue_item(CMD_UNUSED, 8'hFF);                       // dropped
    queue_item(sha1_bsh_pkg::CMD_ABSORB_FINISH, 8'h00);
    queue_item(sha1_bsh_pkg::CMD_ABSORB_FINISH, 8'hFF);
    queue_item(sha1_bsh_pkg::CMD_ABSORB, 8'h61);
    queue_item(sha1_bsh_pkg::CMD_ABSORB, 8'h62);
    queue_item(CMD_UNUSED, 8'h00);                       // noise mid message
    queue_item(sha1_bsh_pkg::CMD_ABSORB_FINISH, 8'h63);
    queue_item(sha1_bsh_pkg::CMD_ABSORB, 8'h80);
    queue_item(sha1_bsh_pkg::CMD_ABSORB, 8'h7F);
    queue_item(sha1_bsh_pkg::CMD_FINISH, 8'h5A);
    queue_item(CMD_UNUSED, 8'h3C);
    queue_item(sha1_bsh_pkg::CMD_FINISH, 8'hC3);         // empty again right after a finish
    // padding just fits in the block / block fills exactly before padding
    add_message(55);
    add_message(64);
    while (items_queued < 250 || finishes_queued < 14) begin
      r = $urandom_range(0, 9);
      if (r < 6) n = $urandom_range(0, 12);
      else if (r < 9) n = $urandom_range(13, 70);
      else n = $urandom_range(100, 130);
      if (items_queued + n > 250) n = (items_queued < 250) ? 250 - items_queued : 0;
      add_message(n);
    end

    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;

    while (pending_bytes.size() != 0 || src_valid) @(posedge clk_i);
    while (digest_expected.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (digest_expected.size() != 0) flag_error("digest words still expected at end");

    if (errors == 0) begin
      $display("sha1_byte_stream_hasher_tb OK");
    end else begin
      $display("sha1_byte_stream_hasher_tb NOT OK");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #10_000_000;
    $display("timeout waiting for the hasher");
    $display("sha1_byte_stream_hasher_tb NOT OK");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/sha1_bsh_pkg.sv
hw/rtl/sha1_bsh_dp.sv
hw/rtl/sha1_bsh_ctrl.sv
hw/rtl/sha1_byte_stream_hasher.sv
hw/rtl/sha1_bsh_checker.sv
bench/sha1_byte_stream_hasher_tb.sv
